// File: rtl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the stereo cabinet filter block
// Widths of the sample, tap and coefficient fields, the MAC operand sizes,
// the sequencer states and the configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

  // Impulse response length and the address widths that follow from it
  localparam int TAP_COUNT  = 512;
  localparam int TAP_ADDR_W = $clog2(TAP_COUNT);
  localparam int FILL_W     = $clog2(TAP_COUNT + 1);

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 18;
  localparam int TAP_IDX_W  = 9;
  localparam int COEFF_W    = 16;
  localparam int MIX_W      = 17;
  localparam int STATE_W    = 24;
  localparam int DIFF_W     = STATE_W + 1;
  localparam int CFG_IDX_W  = 2;

  // Shared MAC operand and accumulator widths
  localparam int CONV_W     = SAMPLE_W + TAP_W + TAP_ADDR_W;
  localparam int A_W        = CONV_W;
  localparam int B_W        = MIX_W + 1;
  localparam int P_W        = A_W + B_W;
  localparam int ACC_W      = 64;
  localparam int MIX_SHIFT  = 15;

  // Saturation limits
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Mix scale and bypass threshold
  localparam logic [MIX_W-1:0] MIX_FULL = MIX_W'(65536);
  localparam logic [MIX_W-1:0] MIX_MIN  = MIX_W'(66);

  // Register reset values
  localparam logic [COEFF_W-1:0] LOWCUT_RESET  = COEFF_W'(65280);
  localparam logic [COEFF_W-1:0] HIGHCUT_RESET = COEFF_W'(16384);
  localparam logic [MIX_W-1:0]   WET_RESET     = MIX_FULL;

  // Item operation codes
  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TAP   = 1'b1
  } op_t;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWCUT   = 2'd0,
    REG_HIGHCUT  = 2'd1,
    REG_WET_MIX  = 2'd2,
    REG_IR_VALID = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_CONV,
    S_DRAIN,
    S_MIX,
    S_OUT
  } seq_state_t;

  // Command to the shared MAC: load replaces the accumulator, shift scales by 2^15
  typedef struct packed {
    logic valid;
    logic load;
    logic shift;
  } mac_cmd_t;

endpackage

`default_nettype wire

// File: rtl/scf_if.sv
// ----------------------------------------------------------------------------
// scf_if: item channels of the stereo cabinet filter block
// Request channel carries frame and tap items, response channel carries the
// mixed stereo samples. Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface scf_req_if import scf_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic signed [SAMPLE_W-1:0]  left_in;
  logic signed [SAMPLE_W-1:0]  right_in;
  logic [TAP_IDX_W-1:0]        tap_index;
  logic signed [TAP_W-1:0]     tap_value;

  modport source (output valid, operation, left_in, right_in, tap_index, tap_value,
                  input ready);
  modport sink   (input valid, operation, left_in, right_in, tap_index, tap_value,
                  output ready);
endinterface

interface scf_rsp_if import scf_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  left_out;
  logic signed [SAMPLE_W-1:0]  right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

// File: rtl/scf_ram.sv
// ----------------------------------------------------------------------------
// scf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/scf_mac.sv
// ----------------------------------------------------------------------------
// scf_mac: shared two-lane multiply-accumulate unit
// Left and right lanes share the b operand. A registered product stage feeds
// a 64-bit accumulator that either loads or adds, optionally scaled by 2^15.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_mac import scf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mac_cmd_t                cmd,
  input  wire logic signed [A_W-1:0]   a_left,
  input  wire logic signed [A_W-1:0]   a_right,
  input  wire logic signed [B_W-1:0]   b,
  output logic signed [ACC_W-1:0]      acc_left,
  output logic signed [ACC_W-1:0]      acc_right
);

  mac_cmd_t                cmd_q;
  logic signed [P_W-1:0]   prod_left;
  logic signed [P_W-1:0]   prod_right;
  logic signed [ACC_W-1:0] add_left;
  logic signed [ACC_W-1:0] add_right;
  logic signed [ACC_W-1:0] base_left;
  logic signed [ACC_W-1:0] base_right;

  // Track the command alongside the product
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd;
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      prod_left  <= a_left * b;
      prod_right <= a_right * b;
    end
  end

  // Scale and select the accumulator base
  always_comb begin
    add_left   = ACC_W'(prod_left);
    add_right  = ACC_W'(prod_right);
    if (cmd_q.shift) begin
      add_left  = add_left <<< MIX_SHIFT;
      add_right = add_right <<< MIX_SHIFT;
    end
    base_left  = cmd_q.load ? '0 : acc_left;
    base_right = cmd_q.load ? '0 : acc_right;
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (cmd_q.valid) begin
      acc_left  <= base_left + add_left;
      acc_right <= base_right + add_right;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stereo_cabinet_fir_with_filters.sv
// ----------------------------------------------------------------------------
// stereo_cabinet_fir_with_filters: stereo low cut, high cut, FIR and dry/wet mix
// Frame items run both channels through two one-pole filters, convolve the
// filtered history with the loaded impulse response and mix wet with dry.
// Tap items load one impulse response tap.
//
//   channel  dir   handshake      payload
//   cfg      in    cfg_we         cfg_index, cfg_data
//   req      in    valid/ready    operation, left_in, right_in, tap_index, tap_value
//   rsp      out   valid/ready    left_out, right_out
//
// A processed frame holds the block for one stereo MAC step per tap, plus
// filter, pipeline drain and mix steps. Tap items leave the block idle and
// ready; bypassed frames go straight from idle to the output step.
// The result waits in an output register; the block takes new items meanwhile
// and only stalls at its final step if the previous result is still not taken.
// Synchronous reset; history reads as zero up to a fill count, so no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_cabinet_fir_with_filters import scf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [MIX_W-1:0]      cfg_data,
  scf_req_if.sink                    req,
  scf_rsp_if.source                  rsp
);

  // Step codes within the filter and mix phases
  localparam logic [2:0] FILT_LC     = 3'd0;
  localparam logic [2:0] FILT_HC     = 3'd1;
  localparam logic [2:0] FILT_LC_UPD = 3'd2;
  localparam logic [2:0] FILT_HC_UPD = 3'd3;
  localparam logic [2:0] FILT_STORE  = 3'd4;
  localparam logic [2:0] DRAIN_LAST  = 3'd1;
  localparam logic [2:0] MIX_WET     = 3'd0;
  localparam logic [2:0] MIX_DRY     = 3'd1;
  localparam logic [2:0] MIX_DONE    = 3'd3;

  localparam logic signed [ACC_W-1:0] HALF_8  = ACC_W'(1) <<< 7;
  localparam logic signed [ACC_W-1:0] HALF_16 = ACC_W'(1) <<< 15;
  localparam logic signed [ACC_W-1:0] HALF_31 = ACC_W'(1) <<< 30;

  // Configuration registers
  logic [COEFF_W-1:0] lowcut_coeff;
  logic [COEFF_W-1:0] highcut_coeff;
  logic [MIX_W-1:0]   wet_mix;
  logic               ir_valid;

  // Sequencer
  seq_state_t             state;
  seq_state_t             state_next;
  logic [2:0]             step;
  logic [2:0]             step_next;
  logic [TAP_ADDR_W-1:0]  tap_cnt;
  logic [TAP_ADDR_W-1:0]  rd_ptr;
  logic                   rd_pending;
  logic                   rd_first;
  logic                   rd_zero;

  // History position and fill count
  logic [TAP_ADDR_W-1:0]  pos;
  logic [FILL_W-1:0]      fill;

  // Per-frame data
  logic signed [SAMPLE_W-1:0] dry_l;
  logic signed [SAMPLE_W-1:0] dry_r;
  logic [MIX_W-1:0]           mix;
  logic signed [DIFF_W-1:0]   y_l;
  logic signed [DIFF_W-1:0]   y_r;
  logic signed [STATE_W-1:0]  lc_l;
  logic signed [STATE_W-1:0]  lc_r;
  logic signed [STATE_W-1:0]  hc_l;
  logic signed [STATE_W-1:0]  hc_r;
  logic signed [SAMPLE_W-1:0] res_l;
  logic signed [SAMPLE_W-1:0] res_r;

  // Output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_l;
  logic signed [SAMPLE_W-1:0] out_r;

  // Combinational helpers
  logic                       accept;
  logic                       out_free;
  logic [MIX_W-1:0]           wet_eff;
  logic                       bypass;
  logic [MIX_W-1:0]           lc_gain;
  logic [MIX_W-1:0]           hc_gain;
  logic [MIX_W-1:0]           dry_gain;
  logic signed [DIFF_W-1:0]   x_l;
  logic signed [DIFF_W-1:0]   x_r;
  logic signed [DIFF_W-1:0]   diff_lc_l;
  logic signed [DIFF_W-1:0]   diff_lc_r;
  logic signed [DIFF_W-1:0]   diff_hc_l;
  logic signed [DIFF_W-1:0]   diff_hc_r;
  logic signed [ACC_W-1:0]    rnd16_l;
  logic signed [ACC_W-1:0]    rnd16_r;
  logic signed [ACC_W-1:0]    rnd8_l;
  logic signed [ACC_W-1:0]    rnd8_r;
  logic signed [ACC_W-1:0]    rnd31_l;
  logic signed [ACC_W-1:0]    rnd31_r;
  logic                       rd_zero_next;
  logic [TAP_ADDR_W-1:0]      rd_ptr_dec;
  logic [TAP_ADDR_W-1:0]      pos_inc;

  // MAC and memory connections
  mac_cmd_t                   mac_cmd;
  logic signed [A_W-1:0]      a_l;
  logic signed [A_W-1:0]      a_r;
  logic signed [B_W-1:0]      b_op;
  logic signed [ACC_W-1:0]    acc_l;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       tap_we;
  logic [TAP_W-1:0]           tap_rdata;
  logic                       hist_we;
  logic [2*SAMPLE_W-1:0]      hist_wdata;
  logic [2*SAMPLE_W-1:0]      hist_rdata;
  logic signed [SAMPLE_W-1:0] hist_l;
  logic signed [SAMPLE_W-1:0] hist_r;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    if (v > ACC_W'(SAMPLE_MAX)) begin
      r = SAMPLE_W'(SAMPLE_MAX);
    end else if (v < ACC_W'(SAMPLE_MIN)) begin
      r = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      r = SAMPLE_W'(v);
    end
    return r;
  endfunction

  // Handshake
  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign rsp.valid  = out_valid;
  assign rsp.left_out  = out_l;
  assign rsp.right_out = out_r;

  // Mix share and bypass decision
  assign wet_eff  = (wet_mix > MIX_FULL) ? MIX_FULL : wet_mix;
  assign bypass   = !ir_valid || (wet_eff < MIX_MIN);
  assign lc_gain  = MIX_FULL - MIX_W'(lowcut_coeff);
  assign hc_gain  = MIX_FULL - MIX_W'(highcut_coeff);
  assign dry_gain = MIX_FULL - mix;

  // Filter differences: x is the input scaled to Q2.22
  assign x_l       = DIFF_W'(dry_l) <<< 7;
  assign x_r       = DIFF_W'(dry_r) <<< 7;
  assign diff_lc_l = x_l - DIFF_W'(lc_l);
  assign diff_lc_r = x_r - DIFF_W'(lc_r);
  assign diff_hc_l = y_l - DIFF_W'(hc_l);
  assign diff_hc_r = y_r - DIFF_W'(hc_r);

  // Round half up at the three scaling points
  assign rnd16_l = (acc_l + HALF_16) >>> 16;
  assign rnd16_r = (acc_r + HALF_16) >>> 16;
  assign rnd8_l  = (ACC_W'(hc_l) + HALF_8) >>> 8;
  assign rnd8_r  = (ACC_W'(hc_r) + HALF_8) >>> 8;
  assign rnd31_l = (acc_l + HALF_31) >>> 31;
  assign rnd31_r = (acc_r + HALF_31) >>> 31;

  // Circular pointers and history fill check
  assign rd_ptr_dec   = (rd_ptr == '0) ? TAP_ADDR_W'(TAP_COUNT - 1) : rd_ptr - 1'b1;
  assign pos_inc      = (pos == TAP_ADDR_W'(TAP_COUNT - 1)) ? '0 : pos + 1'b1;
  assign rd_zero_next = !((fill == FILL_W'(TAP_COUNT)) || (FILL_W'(rd_ptr) < fill));

  assign hist_wdata = {sat_sample(rnd8_l), sat_sample(rnd8_r)};
  assign hist_l     = $signed(hist_rdata[2*SAMPLE_W-1:SAMPLE_W]);
  assign hist_r     = $signed(hist_rdata[SAMPLE_W-1:0]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lowcut_coeff  <= LOWCUT_RESET;
      highcut_coeff <= HIGHCUT_RESET;
      wet_mix       <= WET_RESET;
      ir_valid      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOWCUT:   lowcut_coeff  <= cfg_data[COEFF_W-1:0];
        REG_HIGHCUT:  highcut_coeff <= cfg_data[COEFF_W-1:0];
        REG_WET_MIX:  wet_mix       <= cfg_data;
        REG_IR_VALID: ir_valid      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (accept && (req.operation == OP_FRAME)) begin
          state_next = bypass ? S_OUT : S_FILT;
          step_next  = FILT_LC;
        end
      end
      S_FILT: begin
        if (step == FILT_STORE) begin
          state_next = S_CONV;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_CONV: begin
        if (tap_cnt == TAP_ADDR_W'(TAP_COUNT - 1)) begin
          state_next = S_DRAIN;
          step_next  = '0;
        end
      end
      S_DRAIN: begin
        if (step == DRAIN_LAST) begin
          state_next = S_MIX;
          step_next  = MIX_WET;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_MIX: begin
        if (step == MIX_DONE) begin
          state_next = S_OUT;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        step_next  = '0;
      end
    endcase
  end

  // MAC commands and memory controls
  always_comb begin
    mac_cmd = '0;
    a_l     = '0;
    a_r     = '0;
    b_op    = '0;
    tap_we  = 1'b0;
    hist_we = 1'b0;
    case (state)
      S_IDLE: begin
        tap_we = accept && (req.operation == OP_TAP) &&
                 (int'(req.tap_index) < TAP_COUNT);
      end
      S_FILT: begin
        case (step)
          FILT_LC: begin
            mac_cmd = '{valid: 1'b1, load: 1'b1, shift: 1'b0};
            a_l     = A_W'(diff_lc_l);
            a_r     = A_W'(diff_lc_r);
            b_op    = $signed(B_W'(lc_gain));
          end
          FILT_HC: begin
            mac_cmd = '{valid: 1'b1, load: 1'b1, shift: 1'b0};
            a_l     = A_W'(diff_hc_l);
            a_r     = A_W'(diff_hc_r);
            b_op    = $signed(B_W'(hc_gain));
          end
          FILT_STORE: hist_we = 1'b1;
          default: ;
        endcase
      end
      S_CONV, S_DRAIN: begin
        if (rd_pending) begin
          mac_cmd = '{valid: 1'b1, load: rd_first, shift: 1'b0};
          a_l     = rd_zero ? '0 : A_W'(hist_l);
          a_r     = rd_zero ? '0 : A_W'(hist_r);
          b_op    = $signed(B_W'($signed(tap_rdata)));
        end
      end
      S_MIX: begin
        case (step)
          MIX_WET: begin
            mac_cmd = '{valid: 1'b1, load: 1'b1, shift: 1'b0};
            a_l     = A_W'(acc_l);
            a_r     = A_W'(acc_r);
            b_op    = $signed(B_W'(mix));
          end
          MIX_DRY: begin
            mac_cmd = '{valid: 1'b1, load: 1'b0, shift: 1'b1};
            a_l     = A_W'(dry_l);
            a_r     = A_W'(dry_r);
            b_op    = $signed(B_W'(dry_gain));
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      rd_pending <= (state == S_CONV);
    end
  end

  // Walk taps forward and history backward
  always_ff @(posedge clk) begin
    if (state == S_CONV) begin
      tap_cnt  <= tap_cnt + 1'b1;
      rd_ptr   <= rd_ptr_dec;
      rd_first <= (tap_cnt == '0);
      rd_zero  <= rd_zero_next;
    end else begin
      tap_cnt  <= '0;
      rd_ptr   <= pos;
    end
  end

  // Filter state, history position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      lc_l <= '0;
      lc_r <= '0;
      hc_l <= '0;
      hc_r <= '0;
      pos  <= '0;
      fill <= '0;
    end else begin
      if (state == S_FILT) begin
        case (step)
          FILT_LC_UPD: begin
            lc_l <= lc_l + STATE_W'(rnd16_l);
            lc_r <= lc_r + STATE_W'(rnd16_r);
          end
          FILT_HC_UPD: begin
            hc_l <= hc_l + STATE_W'(rnd16_l);
            hc_r <= hc_r + STATE_W'(rnd16_r);
          end
          FILT_STORE: begin
            if (fill != FILL_W'(TAP_COUNT)) begin
              fill <= fill + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if ((state == S_MIX) && (step == MIX_DONE)) begin
        pos <= pos_inc;
      end
    end
  end

  // Capture the frame, the high cut input and the mixed result
  always_ff @(posedge clk) begin
    if (accept && (req.operation == OP_FRAME)) begin
      dry_l <= req.left_in;
      dry_r <= req.right_in;
      mix   <= wet_eff;
      res_l <= req.left_in;
      res_r <= req.right_in;
    end
    if ((state == S_FILT) && (step == FILT_LC)) begin
      y_l <= diff_lc_l;
      y_r <= diff_lc_r;
    end
    if ((state == S_MIX) && (step == MIX_DONE)) begin
      res_l <= sat_sample(rnd31_l);
      res_r <= sat_sample(rnd31_r);
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      out_l <= res_l;
      out_r <= res_r;
    end
  end

  // Shared stereo MAC
  scf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cmd       (mac_cmd),
    .a_left    (a_l),
    .a_right   (a_r),
    .b         (b_op),
    .acc_left  (acc_l),
    .acc_right (acc_r)
  );

  // Impulse response taps
  scf_ram #(
    .WIDTH (TAP_W),
    .DEPTH (TAP_COUNT)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (TAP_ADDR_W'(req.tap_index)),
    .wdata (req.tap_value),
    .raddr (tap_cnt),
    .rdata (tap_rdata)
  );

  // Stereo history, left in the upper half
  scf_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (TAP_COUNT)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (pos),
    .wdata (hist_wdata),
    .raddr (rd_ptr),
    .rdata (hist_rdata)
  );

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TAP_COUNT))
    else $error("history fill count beyond tap count");

  a_tap_no_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.operation == OP_TAP)) |=> (state == S_IDLE))
    else $error("tap item left the sequencer busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result shown outside the output step");

  a_mac_busy: assert property (@(posedge clk) disable iff (rst)
    mac_cmd.valid |-> ((state != S_IDLE) && (state != S_OUT)))
    else $error("MAC issued while the sequencer is not working");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MIX) && (step == MIX_DONE)) |=> (pos != $past(pos)))
    else $error("history position did not advance after a frame");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stereo cabinet filter block
// Drives frame and tap items through the request channel with bursty pacing,
// stalls the response channel on its own pattern, and checks every mixed
// stereo result against an in-bench cabinet predictor (low cut, high cut,
// FIR over the shared history, dry/wet mix, saturation, bypass rules).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import scf_pkg::*;

  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int DRAIN_CYCLES = TAP_COUNT + 12 + 16;
  localparam int HOLD_CYCLES  = 3000;
  localparam int PHASE_ITEMS  = 8;
  localparam int PHASES       = 8;
  localparam int RELOAD_TAPS  = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [MIX_W-1:0]      cfg_data;

  scf_req_if req_ch ();
  scf_rsp_if rsp_ch ();

  stereo_cabinet_fir_with_filters i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Cabinet predictor state and register copies
  logic signed [SAMPLE_W-1:0] hist [2][TAP_COUNT];
  logic signed [TAP_W-1:0]    ir_taps [TAP_COUNT];
  logic [TAP_ADDR_W-1:0]      hist_pos;
  int                         lowcut_state [2];
  int                         highcut_state [2];
  logic [COEFF_W-1:0]         lowcut_a;
  logic [COEFF_W-1:0]         highcut_b;
  logic [MIX_W-1:0]           wet_m;
  logic                       ir_on;

  stereo_t due_frames[$];
  int      mismatch_count;
  int      cycle_count;
  int      burst_left;
  bit      pace_gaps;
  int      tap_scale;
  int      rsp_hold_seq;

  // Clock
  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cabinet predictor
  // ---------------------------------------------------------------------------

  // Round half up: floor((v + 2^(n-1)) / 2^n)
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint sat_sample(longint v);
    if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
    if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
    return v;
  endfunction

  function automatic void cabinet_reset();
    int t;
    for (t = 0; t < TAP_COUNT; t++) begin
      hist[0][t] = '0;
      hist[1][t] = '0;
      ir_taps[t] = '0;
    end
    hist_pos         = '0;
    lowcut_state[0]  = 0;
    lowcut_state[1]  = 0;
    highcut_state[0] = 0;
    highcut_state[1] = 0;
    lowcut_a         = LOWCUT_RESET;
    highcut_b        = HIGHCUT_RESET;
    wet_m            = WET_RESET;
    ir_on            = 1'b0;
  endfunction

  // Low cut then high cut on one channel; returns the Q2.14 history sample
  function automatic logic signed [SAMPLE_W-1:0] filter_channel(int ch, longint dry);
    longint x, s, y, h, ka, kb;
    x  = dry * 128;
    s  = lowcut_state[ch];
    y  = x - s;
    h  = highcut_state[ch];
    ka = longint'(MIX_FULL) - longint'(lowcut_a);
    kb = longint'(MIX_FULL) - longint'(highcut_b);
    s  = s + round_shift(ka * (x - s), 16);
    h  = h + round_shift(kb * (y - h), 16);
    lowcut_state[ch]  = int'(s);
    highcut_state[ch] = int'(h);
    return SAMPLE_W'(sat_sample(round_shift(h, 8)));
  endfunction

  // FIR sum over the history, newest sample against tap 0
  function automatic longint convolve(int ch, logic [TAP_ADDR_W-1:0] pos);
    longint                acc;
    logic [TAP_ADDR_W-1:0] rp;
    int                    t;
    acc = 0;
    rp  = pos;
    for (t = 0; t < TAP_COUNT; t++) begin
      acc = acc + longint'(hist[ch][rp]) * longint'(ir_taps[t]);
      rp  = rp - 1'b1;
    end
    return acc;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mix_sample(longint dry, longint acc,
                                                            longint m);
    longint v;
    v = dry * (longint'(1) << MIX_SHIFT) * (longint'(MIX_FULL) - m) + acc * m;
    return SAMPLE_W'(sat_sample(round_shift(v, 31)));
  endfunction

  // Advance the predictor by one accepted item; queue the mix it produces
  function automatic void run_cabinet(op_t op, logic signed [SAMPLE_W-1:0] l,
                                      logic signed [SAMPLE_W-1:0] r,
                                      logic [TAP_IDX_W-1:0] idx,
                                      logic signed [TAP_W-1:0] val);
    stereo_t res;
    longint  dl, dr, m;
    if (op == OP_TAP) begin
      if (int'(idx) < TAP_COUNT) ir_taps[idx] = val;
      return;
    end
    dl = l;
    dr = r;
    m  = longint'(wet_m);
    if (m > longint'(MIX_FULL)) m = longint'(MIX_FULL);
    if (!ir_on || m < longint'(MIX_MIN)) begin
      // bypass: dry through, state frozen
      res.left  = l;
      res.right = r;
    end else begin
      hist[0][hist_pos] = filter_channel(0, dl);
      hist[1][hist_pos] = filter_channel(1, dr);
      res.left  = mix_sample(dl, convolve(0, hist_pos), m);
      res.right = mix_sample(dr, convolve(1, hist_pos), m);
      hist_pos  = hist_pos + 1'b1;
    end
    due_frames.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
      1: return $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Tap in [-2^k, 2^k - 1]; full range from k = 17 up
  function automatic logic signed [TAP_W-1:0] random_tap(int k);
    int span;
    if (k >= TAP_W - 1) return TAP_W'($urandom);
    span = 1 << k;
    return TAP_W'(int'($urandom_range(0, 2 * span - 1)) - span);
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  function automatic logic [MIX_W-1:0] pick_mix();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MIX_MIN - 1'b1;
      2: return MIX_MIN;
      3: return MIX_FULL;
      4: return '1;
      5: return MIX_W'($urandom);
      default: return MIX_W'($urandom_range(66, 65536));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until taken, then pace the next one
  task automatic send_item(op_t op, logic signed [SAMPLE_W-1:0] l,
                           logic signed [SAMPLE_W-1:0] r,
                           logic [TAP_IDX_W-1:0] idx, logic signed [TAP_W-1:0] val);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.left_in   <= l;
    req_ch.right_in  <= r;
    req_ch.tap_index <= idx;
    req_ch.tap_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    run_cabinet(op, l, r, idx, val);
    if (pace_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        req_ch.valid <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 700)) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic send_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    send_item(OP_FRAME, l, r, TAP_IDX_W'($urandom), random_tap(TAP_W));
  endtask

  // Write every tap; optional extremes at the first and last tap
  task automatic load_taps(int k, bit with_ends);
    int                      i;
    logic signed [TAP_W-1:0] v;
    tap_scale = k;
    for (i = 0; i < TAP_COUNT; i++) begin
      v = random_tap(k);
      if (with_ends && i == 0) v = TAP_W'(131071);
      if (with_ends && i == TAP_COUNT - 1) v = TAP_W'(-131072);
      send_item(OP_TAP, random_sample(), random_sample(), TAP_IDX_W'(i), v);
    end
  endtask

  // Drop valid, wait for all mixes, then let a tap or frame in flight finish
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [MIX_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Program all four registers while the block is idle
  task automatic apply_config(logic [COEFF_W-1:0] lc, logic [COEFF_W-1:0] hc,
                              logic [MIX_W-1:0] wm, logic irv);
    wait_idle();
    write_reg(REG_LOWCUT, MIX_W'(lc));
    write_reg(REG_HIGHCUT, MIX_W'(hc));
    write_reg(REG_WET_MIX, wm);
    write_reg(REG_IR_VALID, MIX_W'(irv));
    cfg_we    <= 1'b0;
    lowcut_a  = lc;
    highcut_b = hc;
    wet_m     = wm;
    ir_on     = irv;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No IR loaded after reset: frames pass dry
  task automatic test_bypass_without_ir();
    send_item(OP_FRAME, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN), '1, TAP_W'(131071));
    send_item(OP_FRAME, SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MAX), '0, TAP_W'(-131072));
    send_item(OP_FRAME, '0, '0, '0, '0);
    send_item(OP_FRAME, SAMPLE_W'(-1), SAMPLE_W'(1), '1, '1);
  endtask

  // Load the IR with extreme end taps, then enable it fully wet
  task automatic test_load_response();
    load_taps(9, 1'b1);
    apply_config(LOWCUT_RESET, HIGHCUT_RESET, MIX_FULL, 1'b1);
  endtask

  task automatic test_full_wet_extremes();
    send_frame(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));
    send_frame(SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MIN));
    send_frame('0, '0);
    send_frame(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN));
    send_frame(SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MAX));
  endtask

  // Just below and at the bypass threshold, full, above full, zero, half
  task automatic test_mix_edges();
    logic [MIX_W-1:0] mixes [6];
    int               i;
    mixes[0] = MIX_MIN - 1'b1;
    mixes[1] = MIX_MIN;
    mixes[2] = MIX_FULL;
    mixes[3] = '1;
    mixes[4] = '0;
    mixes[5] = MIX_FULL >> 1;
    for (i = 0; i < 6; i++) begin
      apply_config(LOWCUT_RESET, HIGHCUT_RESET, mixes[i], 1'b1);
      send_frame(random_sample(), random_sample());
    end
  endtask

  // Pole extremes of both filters
  task automatic test_filter_edges();
    apply_config('0, '0, MIX_FULL, 1'b1);
    send_frame(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN));
    send_frame(random_sample(), random_sample());
    apply_config('1, '1, MIX_FULL, 1'b1);
    send_frame(SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MAX));
    send_frame(random_sample(), random_sample());
    apply_config('0, '1, MIX_FULL, 1'b1);
    send_frame(random_sample(), random_sample());
    apply_config('1, '0, MIX_FULL, 1'b1);
    send_frame(random_sample(), random_sample());
  endtask

  // Tap write between frames takes effect from the next convolution on
  task automatic test_tap_rewrite();
    send_item(OP_TAP, random_sample(), random_sample(), TAP_IDX_W'($urandom),
              random_tap(tap_scale));
    send_frame(random_sample(), random_sample());
  endtask

  // Receiver holds off long enough that the block stalls its input
  task automatic test_output_stall();
    int n;
    apply_config(LOWCUT_RESET, HIGHCUT_RESET, MIX_FULL, 1'b1);
    pace_gaps    = 1'b0;
    rsp_hold_seq = rsp_hold_seq + 1;
    for (n = 0; n < 8; n++) send_frame(random_sample(), random_sample());
    pace_gaps = 1'b1;
  endtask

  // Phases of random settings, mostly frames with some tap rewrites
  task automatic test_random_traffic();
    int                 phase, n;
    logic [COEFF_W-1:0] lc, hc;
    logic [MIX_W-1:0]   wm;
    logic               irv;
    for (phase = 0; phase < PHASES; phase++) begin
      lc        = pick_coeff();
      hc        = pick_coeff();
      wm        = pick_mix();
      irv       = ($urandom_range(0, 4) != 0);
      pace_gaps = (phase % 4 != 3);
      if (phase == 2 || phase == 5) begin
        // rescale a few taps with the IR switched off
        apply_config(lc, hc, wm, 1'b0);
        tap_scale = $urandom_range(6, 14);
        for (n = 0; n < RELOAD_TAPS; n++)
          send_item(OP_TAP, random_sample(), random_sample(), TAP_IDX_W'($urandom),
                    random_tap(tap_scale));
      end
      apply_config(lc, hc, wm, irv);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 15)
          send_item(OP_TAP, random_sample(), random_sample(), TAP_IDX_W'($urandom),
                    random_tap(tap_scale));
        else
          send_frame(random_sample(), random_sample());
      end
    end
    pace_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_LOWCUT;
    cfg_data         <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_FRAME;
    req_ch.left_in   <= '0;
    req_ch.right_in  <= '0;
    req_ch.tap_index <= '0;
    req_ch.tap_value <= '0;
    cabinet_reset();
    pace_gaps    = 1'b1;
    burst_left   = 1;
    tap_scale    = 9;
    rsp_hold_seq = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bypass_without_ir();
    test_load_response();
    test_full_wet_extremes();
    test_mix_edges();
    test_filter_edges();
    test_tap_rewrite();
    test_output_stall();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: own stall pattern plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : rsp_pacer
    int seg_left, seg_mode, hold_left, hold_seen;
    seg_left  = 0;
    seg_mode  = 1;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != rsp_hold_seq) begin
        hold_seen = rsp_hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        // segments: stall, always ready, or coin toss per cycle
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = (seg_mode == 0) ? $urandom_range(1, 800) : $urandom_range(1, 2000);
        end
        seg_left--;
        case (seg_mode)
          0:       rsp_ch.ready <= 1'b0;
          1:       rsp_ch.ready <= 1'b1;
          default: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // Compare each taken result with the oldest pending mix
  always @(posedge clk) begin : result_check
    stereo_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_frames.size() == 0) begin
        $error("result with no frame pending: left_out %0d right_out %0d",
               rsp_ch.left_out, rsp_ch.right_out);
        mismatch_count++;
      end else begin
        want = due_frames.pop_front();
        if (rsp_ch.left_out !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, rsp_ch.left_out);
          mismatch_count++;
        end
        if (rsp_ch.right_out !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, rsp_ch.right_out);
          mismatch_count++;
        end
      end
    end
  end

  initial mismatch_count = 0;

  // Cycle limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

endmodule
